[src/text_view_byte_formatter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Text view byte formatter - assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_VIEW_BYTE_FORMATTER_UNIT_ASSERT_SVH
`define TEXT_VIEW_BYTE_FORMATTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TVBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tvbf_pkg.sv]
// ----------------------------------------------------------------------------
// tvbf_pkg
// Types and character codes shared by the text view byte formatter.
// ----------------------------------------------------------------------------
package tvbf_pkg;

  localparam int BODY_MAX = 4;
  localparam int BODY_LEN_W = 3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_CARET = 8'h5E;

  localparam logic [6:0] CTRL_LIMIT = 7'd32;
  localparam logic [6:0] CODE_DEL   = 7'd127;
  localparam logic [7:0] CARET_OFS  = 8'd64;

  localparam logic [3:0] BCD_NINE = 4'd9;

  typedef enum logic [2:0] {
    REG_CTRL_VIS      = 3'd0,
    REG_EOL_MARK      = 3'd1,
    REG_TAB_VIS       = 3'd2,
    REG_SQUEEZE_BLANK = 3'd3,
    REG_NUMBER_MODE   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic ctrl_vis;
    logic eol_mark;
    logic tab_vis;
  } view_cfg_t;

  typedef logic [BODY_MAX-1:0][7:0] body_t;

endpackage

[src/text_view_byte_formatter_unit.sv]
// ----------------------------------------------------------------------------
// text_view_byte_formatter_unit
// Formats a text byte stream: optional line numbers, blank-line squeezing,
// visible tabs and line ends, and caret / M- notation for control bytes.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    in_byte_i
//   out      out  out_valid_o / out_ready_i  out_byte_o, last_of_run_o
//   cfg      in   cfg_wr_en_i                cfg_index_i, cfg_wdata_i
//
// One output word per cycle while out_ready_i allows; an input byte occupies
// the item register until it has issued all its output words (1 to 4, plus
// the line number field of max(digits, PAD_WIDTH) + 1 words at a numbered
// line start), and a dropped blank line leaves without a word. A new byte is
// taken in the cycle its predecessor issues its last word. Reset clears the
// counter to one and all settings to zero. out_ready_i low holds the output
// register and the item in place.
// ----------------------------------------------------------------------------
module text_view_byte_formatter_unit #(
  parameter int COUNT_DIGITS = 10,
  parameter int PAD_WIDTH    = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [2:0] cfg_index_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  localparam int NUM_MAX = (COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH;
  localparam int MAX_RES = NUM_MAX + 1 + tvbf_pkg::BODY_MAX;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int SIG_W   = $clog2(COUNT_DIGITS + 1);
  localparam int DIG_W   = $clog2(COUNT_DIGITS);
  localparam logic [CNT_W-1:0] PadW = CNT_W'(PAD_WIDTH);

  // settings
  logic       snp_q, ends_q, tabs_q, squeeze_q;
  logic [1:0] mode_q;

  // item register and line state
  logic             item_v_q;
  logic [7:0]       byte_q;
  logic [IDX_W-1:0] idx_q;
  logic             at_start_q, last_empty_q;

  // output register
  logic       out_v_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  tvbf_pkg::view_cfg_t                  view_cfg;
  tvbf_pkg::body_t                      body;
  logic [tvbf_pkg::BODY_LEN_W-1:0]      body_len;
  logic [SIG_W-1:0]                     sig;
  logic [3:0]                           digit;
  logic [DIG_W-1:0]                     digit_sel;

  logic             blank, squeezed, num_en;
  logic [CNT_W-1:0] sig_ext, num_w, num_off, total, idx_ext, body_pos;
  logic             is_last, out_free, step, done, load, in_acc, incr;
  logic [7:0]       word;

  assign view_cfg = '{ctrl_vis: snp_q, eol_mark: ends_q, tab_vis: tabs_q};

  tvbf_expand u_expand (
    .byte_i (byte_q),
    .cfg_i  (view_cfg),
    .body_o (body),
    .len_o  (body_len)
  );

  tvbf_line_counter #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .incr_i  (incr),
    .sel_i   (digit_sel),
    .digit_o (digit),
    .sig_o   (sig)
  );

  assign blank    = (byte_q == tvbf_pkg::CH_LF);
  assign squeezed = at_start_q & squeeze_q & blank & last_empty_q;
  assign num_en   = at_start_q & (mode_q[1] ? !blank : mode_q[0]);

  assign sig_ext  = CNT_W'(sig);
  assign num_w    = (sig_ext > PadW) ? sig_ext : PadW;
  assign num_off  = num_en ? (num_w + CNT_W'(1)) : '0;
  assign total    = num_off + CNT_W'(body_len);
  assign idx_ext  = CNT_W'(idx_q);
  assign is_last  = (idx_ext == total - CNT_W'(1));
  assign body_pos = idx_ext - num_off;
  assign digit_sel = DIG_W'(num_w - CNT_W'(1) - idx_ext);

  always_comb begin
    if (idx_ext < num_off) begin
      if (idx_ext < num_w - sig_ext) begin
        word = tvbf_pkg::CH_SPACE;
      end else if (idx_ext < num_w) begin
        word = tvbf_pkg::CH_ZERO | {4'd0, digit};
      end else begin
        word = tvbf_pkg::CH_TAB;
      end
    end else begin
      word = body[body_pos[1:0]];
    end
  end

  assign out_free   = !out_v_q | out_ready_i;
  assign step       = item_v_q & (squeezed | out_free);
  assign done       = step & (squeezed | is_last);
  assign load       = step & !squeezed;
  assign incr       = done & !squeezed & num_en;
  assign in_ready_o = !item_v_q | done;
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snp_q     <= 1'b0;
      ends_q    <= 1'b0;
      tabs_q    <= 1'b0;
      squeeze_q <= 1'b0;
      mode_q    <= 2'd0;
    end else if (cfg_wr_en_i) begin
      case (tvbf_pkg::reg_idx_e'(cfg_index_i))
        tvbf_pkg::REG_CTRL_VIS:      snp_q     <= cfg_wdata_i[0];
        tvbf_pkg::REG_EOL_MARK:      ends_q    <= cfg_wdata_i[0];
        tvbf_pkg::REG_TAB_VIS:       tabs_q    <= cfg_wdata_i[0];
        tvbf_pkg::REG_SQUEEZE_BLANK: squeeze_q <= cfg_wdata_i[0];
        tvbf_pkg::REG_NUMBER_MODE:   mode_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q     <= 1'b0;
      idx_q        <= '0;
      at_start_q   <= 1'b1;
      last_empty_q <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        item_v_q <= 1'b1;
      end else if (done) begin
        item_v_q <= 1'b0;
      end
      if (done) begin
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (done && !squeezed) begin
        at_start_q <= blank;
        if (blank) begin
          last_empty_q <= at_start_q;
        end
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_byte_i;
    end
    if (load) begin
      out_byte_q <= word;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

`include "text_view_byte_formatter_unit_assert.svh"

  `TVBF_ASSERT_NOW(a_idx_in_range, item_v_q && !squeezed, idx_ext < total, "index past end")
  `TVBF_ASSERT_NOW(a_last_frees_item, load && is_last, in_ready_o, "last word but item held")
  `TVBF_ASSERT_NEXT(a_newline_starts_line, done && blank, at_start_q, "newline left line open")

endmodule

[src/tvbf_expand.sv]
// ----------------------------------------------------------------------------
// tvbf_expand
// Expands one text byte into its visible form (1 to 4 bytes).
// ----------------------------------------------------------------------------
module tvbf_expand (
  input  logic [7:0]                       byte_i,
  input  tvbf_pkg::view_cfg_t              cfg_i,
  output tvbf_pkg::body_t                  body_o,
  output logic [tvbf_pkg::BODY_LEN_W-1:0]  len_o
);

  logic [6:0] low7;
  logic [7:0] t0, t1;
  logic [tvbf_pkg::BODY_LEN_W-1:0] tlen;

  assign low7 = byte_i[6:0];

  // tail after an optional M- prefix
  always_comb begin
    t0   = {1'b0, low7};
    t1   = '0;
    tlen = tvbf_pkg::BODY_LEN_W'(1);
    if (low7 < tvbf_pkg::CTRL_LIMIT) begin
      t0   = tvbf_pkg::CH_CARET;
      t1   = {1'b0, low7} + tvbf_pkg::CARET_OFS;
      tlen = tvbf_pkg::BODY_LEN_W'(2);
    end else if (low7 == tvbf_pkg::CODE_DEL) begin
      t0   = tvbf_pkg::CH_CARET;
      t1   = tvbf_pkg::CH_QMARK;
      tlen = tvbf_pkg::BODY_LEN_W'(2);
    end
  end

  always_comb begin
    body_o = '0;
    len_o  = tvbf_pkg::BODY_LEN_W'(1);
    if (byte_i == tvbf_pkg::CH_LF) begin
      if (cfg_i.eol_mark) begin
        body_o[0] = tvbf_pkg::CH_DOLLAR;
        body_o[1] = tvbf_pkg::CH_LF;
        len_o     = tvbf_pkg::BODY_LEN_W'(2);
      end else begin
        body_o[0] = tvbf_pkg::CH_LF;
      end
    end else if (byte_i == tvbf_pkg::CH_TAB) begin
      if (cfg_i.tab_vis) begin
        body_o[0] = tvbf_pkg::CH_CARET;
        body_o[1] = tvbf_pkg::CH_I;
        len_o     = tvbf_pkg::BODY_LEN_W'(2);
      end else begin
        body_o[0] = tvbf_pkg::CH_TAB;
      end
    end else if (!cfg_i.ctrl_vis) begin
      body_o[0] = byte_i;
    end else if (byte_i[7]) begin
      body_o[0] = tvbf_pkg::CH_M;
      body_o[1] = tvbf_pkg::CH_DASH;
      body_o[2] = t0;
      body_o[3] = t1;
      len_o     = tlen + tvbf_pkg::BODY_LEN_W'(2);
    end else begin
      body_o[0] = t0;
      body_o[1] = t1;
      len_o     = tlen;
    end
  end

endmodule

[src/tvbf_line_counter.sv]
// ----------------------------------------------------------------------------
// tvbf_line_counter
// Saturating BCD line counter with digit read port and length of the number.
// ----------------------------------------------------------------------------
module tvbf_line_counter #(
  parameter int COUNT_DIGITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               incr_i,
  input  logic [$clog2(COUNT_DIGITS)-1:0]    sel_i,
  output logic [3:0]                         digit_o,
  output logic [$clog2(COUNT_DIGITS+1)-1:0]  sig_o
);

  localparam int SIG_W = $clog2(COUNT_DIGITS + 1);
  localparam logic [COUNT_DIGITS-1:0][3:0] DIGITS_ONE = {{(COUNT_DIGITS-1){4'd0}}, 4'd1};

  logic [COUNT_DIGITS-1:0][3:0] digits_q, digits_d;
  logic [COUNT_DIGITS:0]        carry;

  always_comb begin
    carry[0] = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      carry[i+1] = carry[i] & (digits_q[i] == tvbf_pkg::BCD_NINE);
    end
  end

  always_comb begin
    digits_d = digits_q;
    if (incr_i && !carry[COUNT_DIGITS]) begin
      for (int i = 0; i < COUNT_DIGITS; i++) begin
        if (carry[i]) begin
          digits_d[i] = (digits_q[i] == tvbf_pkg::BCD_NINE) ? 4'd0 : digits_q[i] + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= DIGITS_ONE;
    end else begin
      digits_q <= digits_d;
    end
  end

  // count of significant digits, at least one
  always_comb begin
    sig_o = SIG_W'(1);
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      if (digits_q[i] != 4'd0) begin
        sig_o = SIG_W'(i + 1);
      end
    end
  end

  assign digit_o = (int'(sel_i) < COUNT_DIGITS) ? digits_q[sel_i] : 4'd0;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - text view byte formatter testbench
// Streams text bytes through the formatter under a series of view settings
// (numbering modes, squeeze, visible tabs/ends, caret notation) and checks
// every output word against a cycle-free predictor of the formatted text.
// Both handshakes idle in random bursts; one long receiver hold fills the
// block and backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_DIGITS   = 10;
  localparam int PAD_W        = 6;
  localparam int WATCHDOG_MAX = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 58;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  class formatted_text_board #(int NDIG = 10, int PADW = 6);
    out_word_t  pending_words[$];
    logic [7:0] run_q[$];
    int         mismatches;
    logic       show_np, eol_mark, tab_vis, squeeze;
    logic [1:0] number_mode;
    logic [3:0] count_bcd[NDIG];
    logic       at_start, last_empty;

    function new();
      mismatches  = 0;
      show_np     = 1'b0;
      eol_mark    = 1'b0;
      tab_vis     = 1'b0;
      squeeze     = 1'b0;
      number_mode = 2'd0;
      foreach (count_bcd[i]) count_bcd[i] = 4'd0;
      count_bcd[0] = 4'd1;
      at_start   = 1'b1;
      last_empty = 1'b0;
    endfunction

    function void set_reg(tvbf_pkg::reg_idx_e idx, logic [1:0] val);
      case (idx)
        tvbf_pkg::REG_CTRL_VIS:      show_np = val[0];
        tvbf_pkg::REG_EOL_MARK:      eol_mark = val[0];
        tvbf_pkg::REG_TAB_VIS:       tab_vis = val[0];
        tvbf_pkg::REG_SQUEEZE_BLANK: squeeze = val[0];
        tvbf_pkg::REG_NUMBER_MODE:   number_mode = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // number field, then advance the BCD line count (saturates at all nines)
    function void add_number();
      int  sig;
      bit  all_nine;
      sig = 1;
      for (int i = NDIG - 1; i > 0; i--) begin
        if (count_bcd[i] != 4'd0) begin
          sig = i + 1;
          break;
        end
      end
      for (int i = sig; i < PADW; i++) run_q.push_back(tvbf_pkg::CH_SPACE);
      for (int i = sig - 1; i >= 0; i--) begin
        run_q.push_back(tvbf_pkg::CH_ZERO + {4'd0, count_bcd[i]});
      end
      run_q.push_back(tvbf_pkg::CH_TAB);
      all_nine = 1'b1;
      foreach (count_bcd[i]) if (count_bcd[i] != tvbf_pkg::BCD_NINE) all_nine = 1'b0;
      if (!all_nine) begin
        for (int i = 0; i < NDIG; i++) begin
          if (count_bcd[i] == tvbf_pkg::BCD_NINE) begin
            count_bcd[i] = 4'd0;
          end else begin
            count_bcd[i] = count_bcd[i] + 4'd1;
            break;
          end
        end
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic       was_start, blank;
      logic [7:0] low;
      run_q.delete();
      was_start = at_start;
      blank = (b == tvbf_pkg::CH_LF);
      if (was_start) begin
        if (squeeze && blank && last_empty) return;
        if (number_mode[1]) begin
          if (!blank) add_number();
        end else if (number_mode[0]) begin
          add_number();
        end
        at_start = 1'b0;
      end
      if (b == tvbf_pkg::CH_TAB && tab_vis) begin
        run_q.push_back(tvbf_pkg::CH_CARET);
        run_q.push_back(tvbf_pkg::CH_I);
      end else if (blank) begin
        if (eol_mark) run_q.push_back(tvbf_pkg::CH_DOLLAR);
        run_q.push_back(tvbf_pkg::CH_LF);
        at_start = 1'b1;
        last_empty = was_start;
      end else if (!show_np || b == tvbf_pkg::CH_TAB) begin
        run_q.push_back(b);
      end else begin
        low = b;
        if (b[7]) begin
          run_q.push_back(tvbf_pkg::CH_M);
          run_q.push_back(tvbf_pkg::CH_DASH);
          low = {1'b0, b[6:0]};
        end
        if (low[6:0] < tvbf_pkg::CTRL_LIMIT) begin
          run_q.push_back(tvbf_pkg::CH_CARET);
          run_q.push_back(low + tvbf_pkg::CARET_OFS);
        end else if (low[6:0] == tvbf_pkg::CODE_DEL) begin
          run_q.push_back(tvbf_pkg::CH_CARET);
          run_q.push_back(tvbf_pkg::CH_QMARK);
        end else begin
          run_q.push_back(low);
        end
      end
      foreach (run_q[i]) pending_words.push_back('{run_q[i], i == run_q.size() - 1});
    endfunction

    function void check_word(logic [7:0] data, logic last);
      out_word_t exp_w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %02h last %0b",
                 $time, data, last);
        mismatches++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (data !== exp_w.data) begin
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, exp_w.data, data);
        mismatches++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                 $time, exp_w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_wr_en_i;
  logic [2:0] cfg_index_i;
  logic [1:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  formatted_text_board #(CNT_DIGITS, PAD_W) board;

  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  int items_sent;
  int quiet_cycles;

  text_view_byte_formatter_unit #(
    .COUNT_DIGITS(CNT_DIGITS),
    .PAD_WIDTH   (PAD_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always #6ns clk_i = ~clk_i;

  // handshakes sampled mid-cycle; nothing changes before the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_word(out_byte_o, last_of_run_o);
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    logic rdy;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end
    board.take_byte(b);
    items_sent++;
  endtask

  task automatic settle(int tail);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(tvbf_pkg::reg_idx_e idx, logic [1:0] val);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic set_view(logic np, logic ends, logic tabs, logic sq, logic [1:0] mode);
    settle(8);
    write_reg(tvbf_pkg::REG_CTRL_VIS, {1'b0, np});
    write_reg(tvbf_pkg::REG_EOL_MARK, {1'b0, ends});
    write_reg(tvbf_pkg::REG_TAB_VIS, {1'b0, tabs});
    write_reg(tvbf_pkg::REG_SQUEEZE_BLANK, {1'b0, sq});
    write_reg(tvbf_pkg::REG_NUMBER_MODE, mode);
    cfg_wr_en_i <= 1'b0;
  endtask

  // line content: never a newline
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: b = 8'($urandom_range(32, 126));
      12, 13:  b = tvbf_pkg::CH_TAB;
      14, 15:  b = 8'($urandom_range(0, 31));
      16:      b = 8'h7F;
      default: b = 8'($urandom_range(128, 255));
    endcase
    if (b == tvbf_pkg::CH_LF) b = 8'h0D;
    return b;
  endfunction

  task automatic run_text(int count);
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 4)) send_byte(tvbf_pkg::CH_LF);
        end
        8: begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        9: begin
          len = $urandom_range(1, 5);
          repeat (len) send_byte(pick_text_byte());
        end
        default: begin
          len = $urandom_range(0, 12);
          repeat (len) send_byte(pick_text_byte());
          send_byte(tvbf_pkg::CH_LF);
        end
      endcase
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    cfg_wr_en_i = 1'b0;
    cfg_index_i = tvbf_pkg::REG_CTRL_VIS;
    cfg_wdata_i = 2'd0;
    rst_ni      = 1'b0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_req    = 1'b0;
    items_sent  = 0;
    quiet_cycles = 0;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: plain pass-through
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(tvbf_pkg::CH_LF);
    send_byte(tvbf_pkg::CH_LF);

    // everything on, number all lines; repeated blank gets squeezed
    set_view(1'b1, 1'b1, 1'b1, 1'b1, 2'd1);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h89);
    send_byte(8'h8A);
    send_byte(tvbf_pkg::CH_TAB);
    send_byte(8'h7A);
    send_byte(tvbf_pkg::CH_LF);
    send_byte(tvbf_pkg::CH_LF);
    send_byte(tvbf_pkg::CH_LF);
    send_byte(tvbf_pkg::CH_TAB);
    send_byte(tvbf_pkg::CH_LF);

    // mode three behaves as non-empty numbering
    set_view(1'b1, 1'b0, 1'b0, 1'b0, 2'd3);
    send_byte(tvbf_pkg::CH_LF);
    send_byte(tvbf_pkg::CH_LF);
    send_byte(tvbf_pkg::CH_TAB);
    send_byte(8'hC1);
    send_byte(tvbf_pkg::CH_LF);

    set_view(1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
    run_text(PHASE_ITEMS);
    set_view(1'b1, 1'b1, 1'b1, 1'b1, 2'd1);
    run_text(PHASE_ITEMS);

    // long receiver hold while input keeps coming
    set_view(1'b1, 1'b0, 1'b1, 1'b1, 2'd2);
    hold_req = 1'b1;
    run_text(PHASE_ITEMS);
    set_view(1'b1, 1'b1, 1'b1, 1'b1, 2'd3);
    run_text(PHASE_ITEMS);

    repeat (3) begin
      set_view(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)));
      run_text(PHASE_ITEMS);
    end

    set_view(1'b1, 1'b1, 1'b0, 1'b1, 2'd2);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_text(PHASE_ITEMS);

    settle(20);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/tvbf_pkg.sv
src/tvbf_expand.sv
src/tvbf_line_counter.sv
src/text_view_byte_formatter_unit.sv
tb/tb_top.sv
